// ===== rtl/core/gf2m_affine_hash_filter_unit_defines.svh =====
// Assertion macros shared by the affine hash filter RTL.
`ifndef GF2M_AFFINE_HASH_FILTER_UNIT_DEFINES_SVH
`define GF2M_AFFINE_HASH_FILTER_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define GAHF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define GAHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gahf_pkg.sv =====
// Shared constants for the GF(2^m) affine hash filter.
package gahf_pkg;

    localparam int DATA_W          = 32;
    localparam int DEG_W           = 6;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_DEGREE_DEF  = 32;
    localparam int STEPS_PER_STAGE = 8;

    localparam logic [DEG_W-1:0] DEG_MIN = DEG_W'(2);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_LOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MULT_KEY     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ADD_KEY      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TAG   = CFG_IDX_W'(5);

    // Reset values of the configuration registers
    localparam logic [DEG_W-1:0]  RST_FIELD_DEGREE = DEG_W'(32);
    localparam logic [DATA_W-1:0] RST_MODULUS_LOW  = DATA_W'(141);
    localparam logic [DATA_W-1:0] RST_MULT_KEY     = DATA_W'(1);
    localparam logic [DATA_W-1:0] RST_ADD_KEY      = DATA_W'(0);
    localparam logic [DEG_W-1:0]  RST_TAG_BITS     = DEG_W'(24);
    localparam logic [DATA_W-1:0] RST_TARGET_TAG   = DATA_W'(0);

endpackage

// ===== rtl/core/gahf_mul_stage.sv =====
// One pipeline stage of the shift-and-reduce GF(2^m) multiplier.
module gahf_mul_stage #(
    parameter int W     = gahf_pkg::MAX_DEGREE_DEF,
    parameter int NSTEP = gahf_pkg::STEPS_PER_STAGE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [gahf_pkg::DATA_W-1:0] up_element,
    input  logic [W-1:0]                up_x,
    input  logic [W-1:0]                up_acc,
    output logic                        down_valid,
    input  logic                        down_ready,
    output logic [gahf_pkg::DATA_W-1:0] down_element,
    output logic [W-1:0]                down_x,
    output logic [W-1:0]                down_acc,
    input  logic [W:0]                  fpoly,
    input  logic [W-1:0]                mult,
    input  logic [W:0]                  top
);
    import gahf_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] element_reg;
    logic [W-1:0]      x_reg;
    logic [W-1:0]      acc_reg;
    logic [W-1:0]      acc_c;
    logic [W-1:0]      x_c;

    // Shift the accumulator, reduce by f on overflow, add a when the x bit is set
    function automatic logic [W-1:0] mul_step(
        input logic [W-1:0] acc,
        input logic         xbit,
        input logic [W-1:0] a,
        input logic [W:0]   f,
        input logic [W:0]   t
    );
        logic [W:0] sh;
        sh = {acc, 1'b0};
        if (|(sh & t))
        begin
            sh = sh ^ f;
        end
        return sh[W-1:0] ^ (xbit ? a : '0);
    endfunction

    // Run this stage's share of the multiply, MSB of x first
    always_comb
    begin
        acc_c = up_acc;
        x_c   = up_x;
        for (int t = 0; t < STEPS_PER_STAGE; t++)
        begin
            if (t < NSTEP)
            begin
                acc_c = mul_step(acc_c, x_c[W-1], mult, fpoly, top);
                x_c   = x_c << 1;
            end
        end
    end

    // Advance when the next stage takes the held request or the stage is empty
    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload only on a taken request
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            element_reg <= up_element;
            x_reg       <= x_c;
            acc_reg     <= acc_c;
        end
    end

    assign down_valid   = valid_reg;
    assign down_element = element_reg;
    assign down_x       = x_reg;
    assign down_acc     = acc_reg;

endmodule

// ===== rtl/core/gf2m_affine_hash_filter_unit.sv =====
// Top level: GF(2^m) affine hash h = a*x mod f xor b, tag extract and target compare.
// Each accepted request passes one register per multiply stage and then the output
// register before the result can be taken.
// Throughput: one element per cycle while results are taken; each multiply stage runs up to eight shift-reduce steps.
// A stalled result holds the pipeline in place; empty stages still fill behind it.
// Reset clears all stage valid bits and loads the configuration reset values.
module gf2m_affine_hash_filter_unit #(
    parameter int MAX_DEGREE = gahf_pkg::MAX_DEGREE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [gahf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gahf_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           element_valid,
    output logic                           element_ready,
    input  logic [gahf_pkg::DATA_W-1:0]    element,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [gahf_pkg::DATA_W-1:0]    element_out,
    output logic [gahf_pkg::DATA_W-1:0]    tag,
    output logic                           is_match
);
    import gahf_pkg::*;

`include "gf2m_affine_hash_filter_unit_defines.svh"

    localparam int W          = MAX_DEGREE;
    localparam int NUM_STAGES = (MAX_DEGREE + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(MAX_DEGREE);

    // Configuration registers
    logic [DEG_W-1:0]  field_degree_reg;
    logic [DATA_W-1:0] modulus_low_reg;
    logic [DATA_W-1:0] mult_key_reg;
    logic [DATA_W-1:0] add_key_reg;
    logic [DEG_W-1:0]  tag_bits_reg;
    logic [DATA_W-1:0] target_tag_reg;

    // Derived field values
    logic [DEG_W-1:0] m_eff;
    logic [W-1:0]     field_mask;
    logic [W-1:0]     tag_mask;
    logic [W:0]       top_bit;
    logic [W:0]       fpoly;
    logic [W-1:0]     mult_w;
    logic [W-1:0]     add_w;
    logic [W-1:0]     target_w;

    // Pipeline links
    logic              valid_s   [0:NUM_STAGES];
    logic              ready_s   [0:NUM_STAGES];
    logic [DATA_W-1:0] element_s [0:NUM_STAGES];
    logic [W-1:0]      x_s       [0:NUM_STAGES];
    logic [W-1:0]      acc_s     [0:NUM_STAGES];

    // Output stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] element_out_reg;
    logic [W-1:0]      tag_reg;
    logic              match_reg;
    logic [W-1:0]      hash_c;
    logic [W-1:0]      tag_c;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_degree_reg <= RST_FIELD_DEGREE;
            modulus_low_reg  <= RST_MODULUS_LOW;
            mult_key_reg     <= RST_MULT_KEY;
            add_key_reg      <= RST_ADD_KEY;
            tag_bits_reg     <= RST_TAG_BITS;
            target_tag_reg   <= RST_TARGET_TAG;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FIELD_DEGREE: field_degree_reg <= cfg_data[DEG_W-1:0];
                REG_MODULUS_LOW:  modulus_low_reg  <= cfg_data;
                REG_MULT_KEY:     mult_key_reg     <= cfg_data;
                REG_ADD_KEY:      add_key_reg      <= cfg_data;
                REG_TAG_BITS:     tag_bits_reg     <= cfg_data[DEG_W-1:0];
                REG_TARGET_TAG:   target_tag_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp the degree into the supported range
    always_comb
    begin
        if (field_degree_reg < DEG_MIN)
        begin
            m_eff = DEG_MIN;
        end
        else if (field_degree_reg > DEG_MAX)
        begin
            m_eff = DEG_MAX;
        end
        else
        begin
            m_eff = field_degree_reg;
        end
    end

    // Build the coefficient masks and the implied leading term
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            field_mask[i] = (DEG_W'(i) < m_eff);
            tag_mask[i]   = (DEG_W'(i) < tag_bits_reg);
        end
        for (int i = 0; i <= W; i++)
        begin
            top_bit[i] = (DEG_W'(i) == m_eff);
        end
    end

    assign fpoly    = top_bit | {1'b0, W'(modulus_low_reg) & field_mask};
    assign mult_w   = W'(mult_key_reg) & field_mask;
    assign add_w    = W'(add_key_reg) & field_mask;
    assign target_w = W'(target_tag_reg) & field_mask;

    // Feed the first multiply stage straight from the request port
    assign valid_s[0]    = element_valid;
    assign element_ready = ready_s[0];
    assign element_s[0]  = element;
    assign x_s[0]        = W'(element) & field_mask;
    assign acc_s[0]      = '0;

    // Multiply stages, eight steps each, the last one takes the remainder
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_mul
        localparam int LEFT  = MAX_DEGREE - g * STEPS_PER_STAGE;
        localparam int NSTEP = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

        gahf_mul_stage #(
            .W     (W),
            .NSTEP (NSTEP)
        ) u_stage (
            .clk          (clk),
            .rst_n        (rst_n),
            .up_valid     (valid_s[g]),
            .up_ready     (ready_s[g]),
            .up_element   (element_s[g]),
            .up_x         (x_s[g]),
            .up_acc       (acc_s[g]),
            .down_valid   (valid_s[g+1]),
            .down_ready   (ready_s[g+1]),
            .down_element (element_s[g+1]),
            .down_x       (x_s[g+1]),
            .down_acc     (acc_s[g+1]),
            .fpoly        (fpoly),
            .mult         (mult_w),
            .top          (top_bit)
        );
    end

    // Add the offset and keep the low k coefficients
    assign hash_c = acc_s[NUM_STAGES] ^ add_w;
    assign tag_c  = hash_c & tag_mask;

    // Hold the result until the consumer takes it
    assign ready_s[NUM_STAGES] = !out_valid_reg || result_ready;
    assign out_valid_next      = ready_s[NUM_STAGES] ? valid_s[NUM_STAGES] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_s[NUM_STAGES] && ready_s[NUM_STAGES])
        begin
            element_out_reg <= element_s[NUM_STAGES];
            tag_reg         <= tag_c;
            match_reg       <= (tag_c == target_w);
        end
    end

    assign result_valid = out_valid_reg;
    assign element_out  = element_out_reg;
    assign tag          = DATA_W'(tag_reg);
    assign is_match     = match_reg;

    // Backpressure at the input only when the first stage holds a request
    `GAHF_ASSERT_SAME(a_in_stall_full, clk, rst_n, !element_ready, valid_s[1],
        "input stalled with an empty first stage")
    // The output stage stalls only while it holds a result
    `GAHF_ASSERT_SAME(a_out_stall_full, clk, rst_n, !ready_s[NUM_STAGES], result_valid,
        "pipeline stalled with an empty output stage")
    // A delivered tag has no coefficients at or above k
    `GAHF_ASSERT_SAME(a_tag_width, clk, rst_n, result_valid, ((tag_reg & ~tag_mask) == '0),
        "tag carries bits above the tag width")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the GF(2^m) affine hash filter unit.
`timescale 1ns / 100ps

module tb;
    import gahf_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int LATENCY      = (MAX_DEGREE_DEF + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE + 1;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [DATA_W-1:0] value;
        int unsigned       gap;
    } element_req_t;

    typedef struct {
        logic [DATA_W-1:0] element;
        logic [DATA_W-1:0] tag;
        logic              is_match;
    } hash_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DATA_W-1:0] cfg_data      = '0;
    logic              element_valid = 1'b0;
    logic              element_ready;
    logic [DATA_W-1:0] element       = '0;
    logic              result_valid;
    logic              result_ready  = 1'b0;
    logic [DATA_W-1:0] element_out;
    logic [DATA_W-1:0] tag;
    logic              is_match;

    // Shadow copy of the configuration registers
    logic [DEG_W-1:0]  cfg_degree  = RST_FIELD_DEGREE;
    logic [DATA_W-1:0] cfg_modulus = RST_MODULUS_LOW;
    logic [DATA_W-1:0] cfg_mult    = RST_MULT_KEY;
    logic [DATA_W-1:0] cfg_add     = RST_ADD_KEY;
    logic [DEG_W-1:0]  cfg_tagbits = RST_TAG_BITS;
    logic [DATA_W-1:0] cfg_target  = RST_TARGET_TAG;

    element_req_t elements_to_send[$];
    hash_result_t hash_results_due[$];

    element_req_t next_req;
    logic         drv_busy      = 1'b0;
    logic         have_next     = 1'b0;
    int unsigned  gap_left      = 0;
    logic         element_taken = 1'b0;
    logic         result_taken  = 1'b0;
    logic         hold_request  = 1'b0;
    int unsigned  ready_wait    = 0;
    logic         send_idle     = 1'b0;
    logic         rcv_idle      = 1'b0;

    int unsigned fail_count     = 0;
    int unsigned elements_hashed = 0;
    int unsigned results_seen   = 0;
    int unsigned matches_seen   = 0;
    int unsigned settings_used  = 0;
    int unsigned stall_run      = 0;
    int unsigned longest_stall  = 0;
    int unsigned cycle_count    = 0;

    gf2m_affine_hash_filter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_valid (element_valid),
        .element_ready (element_ready),
        .element       (element),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .element_out   (element_out),
        .tag           (tag),
        .is_match      (is_match)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Compute (a*x mod f) xor b, truncate to the tag width and compare with the target
    function automatic hash_result_t predict_hash(logic [DATA_W-1:0] x);
        hash_result_t res;
        int           m;
        logic [63:0]  field_mask;
        logic [63:0]  fpoly;
        logic [63:0]  a;
        logic [63:0]  xv;
        logic [63:0]  acc;
        logic [63:0]  tag_mask;
        logic [63:0]  tag_val;
        m = int'(cfg_degree);
        if (m < 2)
            m = 2;
        if (m > MAX_DEGREE_DEF)
            m = MAX_DEGREE_DEF;
        field_mask = (64'd1 << m) - 64'd1;
        fpoly      = (64'd1 << m) | ({32'd0, cfg_modulus} & field_mask);
        a          = {32'd0, cfg_mult} & field_mask;
        xv         = {32'd0, x} & field_mask;
        acc        = '0;
        // shift and add, most significant coefficient first
        for (int i = m - 1; i >= 0; i--)
        begin
            acc = acc << 1;
            if (acc[m])
                acc = acc ^ fpoly;
            if (xv[i])
                acc = acc ^ a;
        end
        acc         = acc ^ ({32'd0, cfg_add} & field_mask);
        tag_mask    = (64'd1 << cfg_tagbits) - 64'd1;
        tag_val     = acc & tag_mask;
        res.element = x;
        res.tag     = tag_val[DATA_W-1:0];
        res.is_match = (tag_val == ({32'd0, cfg_target} & field_mask));
        return res;
    endfunction

    // Drive element requests from the pending queue, with a drawn gap before each
    always @(negedge clk)
    begin : driver
        if (rst_n)
        begin
            if (element_taken)
            begin
                element_taken = 1'b0;
                drv_busy      = 1'b0;
            end
            if (!drv_busy && !have_next && elements_to_send.size() > 0)
            begin
                next_req  = elements_to_send.pop_front();
                have_next = 1'b1;
                gap_left  = next_req.gap;
            end
            if (!drv_busy && have_next)
            begin
                if (gap_left == 0)
                begin
                    drv_busy  = 1'b1;
                    have_next = 1'b0;
                    element  <= next_req.value;
                end
                else
                    gap_left--;
            end
            element_valid <= drv_busy;
        end
    end

    // Drop result_ready for a drawn number of cycles after each result when rcv_idle is set, or for a long hold
    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                ready_wait   = rcv_idle ? $urandom_range(0, 19) : 0;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                ready_wait   = HOLD_CYCLES;
            end
            if (ready_wait > 0)
            begin
                result_ready <= 1'b0;
                ready_wait--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Check each result against the oldest prediction, then record accepted requests
    always @(posedge clk)
    begin : monitor
        hash_result_t due;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                result_taken = 1'b1;
                results_seen++;
                if (hash_results_due.size() == 0)
                begin
                    $error("result with nothing pending: element_out=%h tag=%h",
                           element_out, tag);
                    fail_count++;
                end
                else
                begin
                    due = hash_results_due.pop_front();
                    if (element_out !== due.element)
                    begin
                        $error("element_out mismatch: expected %h, got %h",
                               due.element, element_out);
                        fail_count++;
                    end
                    if (tag !== due.tag)
                    begin
                        $error("tag mismatch: expected %h, got %h", due.tag, tag);
                        fail_count++;
                    end
                    if (is_match !== due.is_match)
                    begin
                        $error("is_match mismatch: expected %b, got %b",
                               due.is_match, is_match);
                        fail_count++;
                    end
                    if (due.is_match)
                        matches_seen++;
                end
            end
            if (element_valid && element_ready)
            begin
                hash_results_due.insert(hash_results_due.size(), predict_hash(element));
                element_taken = 1'b1;
                elements_hashed++;
            end
            if (element_valid && !element_ready)
            begin
                stall_run++;
                if (stall_run > longest_stall)
                    longest_stall = stall_run;
            end
            else
                stall_run = 0;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Write one register and keep the shadow copy in step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_FIELD_DEGREE: cfg_degree  = data[DEG_W-1:0];
            REG_MODULUS_LOW:  cfg_modulus = data;
            REG_MULT_KEY:     cfg_mult    = data;
            REG_ADD_KEY:      cfg_add     = data;
            REG_TAG_BITS:     cfg_tagbits = data[DEG_W-1:0];
            REG_TARGET_TAG:   cfg_target  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] deg, input logic [DATA_W-1:0] modl,
                                 input logic [DATA_W-1:0] mult, input logic [DATA_W-1:0] add,
                                 input logic [DATA_W-1:0] tagb, input logic [DATA_W-1:0] tgt);
        write_reg(REG_FIELD_DEGREE, deg);
        write_reg(REG_MODULUS_LOW, modl);
        write_reg(REG_MULT_KEY, mult);
        write_reg(REG_ADD_KEY, add);
        write_reg(REG_TAG_BITS, tagb);
        write_reg(REG_TARGET_TAG, tgt);
        settings_used++;
        @(posedge clk);
    endtask

    task automatic push_element(input logic [DATA_W-1:0] v);
        element_req_t req;
        req.value = v;
        req.gap   = send_idle ? $urandom_range(0, 19) : 0;
        elements_to_send.insert(elements_to_send.size(), req);
    endtask

    // Hold the sender until every pending result has drained
    task automatic wait_idle();
        while (elements_to_send.size() != 0 || drv_busy || have_next ||
               hash_results_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 3) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned       random_sent;
        int unsigned       phase_no;
        int unsigned       n_items;
        int unsigned       tmode;
        logic              long_hold;
        logic [DATA_W-1:0] r_deg;
        logic [DATA_W-1:0] r_mod;
        logic [DATA_W-1:0] r_mult;
        logic [DATA_W-1:0] r_add;
        logic [DATA_W-1:0] r_tagb;
        logic [DATA_W-1:0] r_tgt;
        logic [DATA_W-1:0] hit_elem;
        hash_result_t      hit_res;

        random_sent = 0;
        phase_no    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset values of all registers
        push_element(32'h0000_0000);
        push_element(32'h0000_0001);
        push_element(32'h8000_0000);
        push_element(32'hFFFF_FFFF);
        push_element(32'h5A5A_A5A5);
        wait_idle();

        // Degree below minimum, all-ones keys, tag wider than field, high target bits ignored
        rcv_idle = 1'b1;
        apply_setting(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd63, 32'hFFFF_FFFF);
        push_element(32'h0000_0000);
        push_element(32'hFFFF_FFFF);
        push_element(32'h0000_0002);
        push_element(32'hFFFF_FFFD);
        wait_idle();

        // Degree above maximum, reducible modulus x^m, tag width zero
        send_idle = 1'b1;
        apply_setting(32'd63, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'd0, 32'h0000_0000);
        push_element(32'h1234_5678);
        push_element(32'hFFFF_FFFF);
        push_element(32'h0000_0000);
        wait_idle();

        // Byte field, target with a bit above the tag width never matches
        apply_setting(32'd8, 32'h0000_001B, 32'h0000_0003, 32'h0000_0000, 32'd4, 32'h0000_0010);
        push_element(32'h0000_0053);
        push_element(32'h0000_00CA);
        push_element(32'hFFFF_FF01);
        wait_idle();

        // Full width with a target hit on purpose
        apply_setting(32'd32, 32'h0000_008D, $urandom, $urandom, 32'd32, 32'h0000_0000);
        hit_res = predict_hash(32'hDEAD_BEEF);
        write_reg(REG_TARGET_TAG, hit_res.tag);
        @(posedge clk);
        push_element(32'hDEAD_BEEF);
        push_element($urandom);
        push_element(32'hDEAD_BEEF);
        wait_idle();

        // Random settings, each followed by a burst of elements
        while (random_sent < RANDOM_ITEMS)
        begin
            long_hold = (phase_no == 2);
            send_idle = long_hold ? 1'b0 : ($urandom_range(0, 2) != 0);
            rcv_idle  = $urandom_range(0, 2) != 0;

            case ($urandom_range(0, 7))
                0:       r_deg = $urandom_range(0, 1);
                1:       r_deg = 2;
                2:       r_deg = 32;
                3:       r_deg = $urandom_range(33, 63);
                default: r_deg = $urandom_range(3, 31);
            endcase
            case ($urandom_range(0, 3))
                0:       r_mod = 32'h0000_0000;
                1:       r_mod = 32'hFFFF_FFFF;
                default: r_mod = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       r_mult = 32'h0000_0000;
                1:       r_mult = 32'h0000_0001;
                2:       r_mult = 32'hFFFF_FFFF;
                default: r_mult = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       r_add = 32'h0000_0000;
                1:       r_add = 32'hFFFF_FFFF;
                default: r_add = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       r_tagb = 0;
                1:       r_tagb = 1;
                2:       r_tagb = 32;
                default: r_tagb = $urandom_range(1, 63);
            endcase
            tmode    = $urandom_range(0, 3);
            hit_elem = $urandom;
            r_tgt    = (tmode == 2) ? $urandom : $urandom_range(0, 3);
            apply_setting(r_deg, r_mod, r_mult, r_add, r_tagb, r_tgt);

            // Aim the target at one element's tag so matches are not rare
            if (tmode < 2)
            begin
                hit_res = predict_hash(hit_elem);
                write_reg(REG_TARGET_TAG, hit_res.tag);
                @(posedge clk);
            end

            if (long_hold)
                hold_request = 1'b1;
            n_items = long_hold ? 40 : $urandom_range(20, 70);
            for (int unsigned i = 0; i < n_items; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    push_element((tmode < 2) ? hit_elem : $urandom);
                    2:       push_element($urandom_range(0, 15));
                    default: push_element($urandom);
                endcase
                random_sent++;
            end
            wait_idle();
            phase_no++;
        end

        repeat (LATENCY + 5) @(negedge clk);
        $display("hashed %0d elements under %0d register settings, %0d results checked",
                 elements_hashed, settings_used, results_seen);
        $display("%0d target matches, longest input stall %0d cycles",
                 matches_seen, longest_stall);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
